// ----- design/assert_macros.svh -----
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define LWDG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define LWDG_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`endif

// ----- design/lwdg_pkg.sv -----
// Shared types and constants of the load watermark frequency governor.
`default_nettype none
package lwdg_pkg;

   localparam int FREQ_W     = 32;
   localparam int PROD_W     = 42;
   localparam int PERMILLE_W = 10;
   localparam int LEVEL_W    = 5;
   localparam int CNT_W      = 6;
   localparam int MUL_STEPS  = 32;
   localparam int DIV_STEPS  = 42;

   localparam int DEFAULT_MAX_LEVELS = 16;

   localparam logic [PERMILLE_W-1:0] PERMILLE_FULL  = 10'd1000;
   localparam logic [PERMILLE_W-1:0] RST_LOAD_TGT   = 10'd800;
   localparam logic [PERMILLE_W-1:0] RST_LOAD_MAX   = 10'd950;
   localparam logic [LEVEL_W-1:0]    RST_LEVELS     = 5'd1;
   localparam logic [FREQ_W-1:0]     THOUSAND       = 32'd1000;

   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_SAMPLE = 2'd1;
   localparam logic [1:0] ACT_WMARKS = 2'd2;

   localparam logic [1:0] CSR_LOAD_TARGET = 2'd0;
   localparam logic [1:0] CSR_LOAD_MAX    = 2'd1;
   localparam logic [1:0] CSR_LEVEL_COUNT = 2'd2;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_LOAD,
      ST_DIV_LOAD,
      ST_MUL_REL,
      ST_DIV_REL,
      ST_DIV_CUR,
      ST_MUL_KEY,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN1_END,
      ST_DIV_KHZ,
      ST_SCAN2_END,
      ST_LO_DIV,
      ST_LO_MUL,
      ST_LO_SCALE,
      ST_HI_DIV,
      ST_HI_MUL,
      ST_HI_SCALE,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

// ----- design/lwdg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lwdg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/lwdg_serial_unit.sv -----
// Bit-serial multiplier and restoring divider, one bit per cycle.
`default_nettype none
module lwdg_serial_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lwdg_pkg::unit_cmd_type      cmd,
   input  wire logic [lwdg_pkg::PROD_W-1:0] opa,
   input  wire logic [lwdg_pkg::FREQ_W-1:0] opb,
   output logic                             done,
   output logic      [lwdg_pkg::PROD_W-1:0] result
);
   import lwdg_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   op_type              op_ff, op_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   work_ff, work_in;
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [FREQ_W-1:0]   b_ff, b_in;
   logic [FREQ_W:0]     rem_ff, rem_in;
   logic [FREQ_W:0]     rem_sh;
   logic                fits;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      work_in  = work_ff;
      mcand_in = mcand_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      rem_sh   = {rem_ff[FREQ_W-1:0], work_ff[PROD_W-1]};
      fits     = rem_sh >= {1'b0, b_ff};
      if (!busy_ff && cmd.start) begin
         busy_in  = 1'b1;
         op_in    = cmd.op;
         b_in     = opb;
         mcand_in = opa;
         rem_in   = '0;
         if (cmd.op == OP_MUL) begin
            work_in = '0;
            cnt_in  = CNT_W'(MUL_STEPS - 1);
         end else begin
            work_in = opa;
            cnt_in  = CNT_W'(DIV_STEPS - 1);
         end
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            // Multiplier bits are consumed from the top, so the sum doubles each step.
            work_in = {work_ff[PROD_W-2:0], 1'b0} + (b_ff[FREQ_W-1] ? mcand_ff : '0);
            b_in    = {b_ff[FREQ_W-2:0], 1'b0};
         end else begin
            rem_in  = fits ? (rem_sh - {1'b0, b_ff}) : rem_sh;
            work_in = {work_ff[PROD_W-2:0], fits};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      cnt_ff   <= cnt_in;
      work_ff  <= work_in;
      mcand_ff <= mcand_in;
      b_ff     <= b_in;
      rem_ff   <= rem_in;
   end

   assign done   = done_ff;
   assign result = work_ff;

endmodule
`default_nettype wire

// ----- design/load_watermark_dvfs_governor_top.sv -----
// Load watermark frequency governor: table, sequencer and serial arithmetic.
//
// Input items arrive on the req_ stream. tuser carries the action: a table
// write stores entry_freq at entry_index, a load sample picks a new frequency
// and its watermarks, a watermark reset computes watermarks for the lowest entry.
// Every item gives exactly one result transfer on the rsp_ stream.
// The target load, maximum load and level count registers are written over the
// csr_ port while the block is idle, a rule for the user that the block itself
// does not enforce; they take effect for the next item. The block works on one
// item at a time. A table write, a sample with zero total time or an unused
// action offers its result in the cycle after the input transfer.
// A load sample runs through a one-bit-per-cycle multiplier/divider (up to
// thirteen operations) and two passes over the table.
// After reset the registers hold 800, 950 and 1 and no result is pending; the
// table contents are undefined until written.
// A result waits in the output register while rsp_tready is low; req_tready
// stays low until that result is taken.
`default_nettype none
module load_watermark_dvfs_governor_top #(
   parameter int MAX_LEVELS = lwdg_pkg::DEFAULT_MAX_LEVELS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // entry_index, entry_freq, busy count, total count, current_freq, zero fill
   input  wire logic [135:0] req_tdata,
   // action
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // target_freq, low_wmark, high_wmark, zero fill
   output logic      [55:0]  rsp_tdata,
   // freq_valid, wmarks_valid
   output logic      [1:0]   rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [9:0]   csr_wdata
);
   import lwdg_pkg::*;

   localparam int AW = $clog2(MAX_LEVELS);

   // Input payload.
   logic [3:0]        in_idx;
   logic [FREQ_W-1:0] in_efreq, in_busy, in_total, in_cur;
   logic [1:0]        in_action;

   assign in_idx    = req_tdata[3:0];
   assign in_efreq  = req_tdata[35:4];
   assign in_busy   = req_tdata[67:36];
   assign in_total  = req_tdata[99:68];
   assign in_cur    = req_tdata[131:100];
   assign in_action = req_tuser;

   // Configuration registers.
   logic [PERMILLE_W-1:0] tgt_load_ff, max_load_ff;
   logic [LEVEL_W-1:0]    level_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_load_ff    <= RST_LOAD_TGT;
         max_load_ff    <= RST_LOAD_MAX;
         level_count_ff <= RST_LEVELS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOAD_TARGET: tgt_load_ff    <= csr_wdata;
            CSR_LOAD_MAX:    max_load_ff    <= csr_wdata;
            CSR_LEVEL_COUNT: level_count_ff <= csr_wdata[LEVEL_W-1:0];
            default:         ;
         endcase
      end
   end

   logic [AW-1:0] last_idx;

   always_comb begin
      if (level_count_ff == '0) begin
         last_idx = '0;
      end else if (32'(level_count_ff) > MAX_LEVELS) begin
         last_idx = AW'(MAX_LEVELS - 1);
      end else begin
         last_idx = AW'(level_count_ff - 1'b1);
      end
   end

   // Sequencer and datapath registers.
   state_type             state_ff, state_in;
   logic                  launch_ff;
   logic [1:0]            act_ff;
   logic [FREQ_W-1:0]     busy_ff, total_ff, cur_ff;
   logic                  overload_ff;
   logic                  second_ff;
   logic [19:0]           rel_ff;
   logic [PROD_W-1:0]     key_ff;
   logic [FREQ_W-1:0]     f_ff, khz_ff, above_ff, below_ff;
   logic [AW-1:0]         scan_idx_ff;
   logic [FREQ_W-1:0]     t0_ff, tlast_ff, ge_ff, gt_ff, lt_ff;
   logic                  ge_fnd_ff, gt_fnd_ff, lt_fnd_ff;
   logic [FREQ_W-1:0]     target_ff;
   logic                  fv_ff, wv_ff;
   logic [PERMILLE_W-1:0] lo_ff, hi_ff;

   // Arithmetic unit and table memory.
   unit_cmd_type      cmd;
   logic [PROD_W-1:0] opa, res;
   logic [FREQ_W-1:0] opb, rd_data;
   logic              unit_done;
   logic              arith_state;
   logic              accept;
   logic              tbl_we;

   assign accept = req_tvalid && req_tready;
   assign tbl_we = accept && (in_action == ACT_WRITE) && (32'(in_idx) < MAX_LEVELS);

   lwdg_serial_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .done   (unit_done),
      .result (res)
   );

   lwdg_ram #(
      .WIDTH (FREQ_W),
      .DEPTH (MAX_LEVELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (AW'(in_idx)),
      .wr_data (in_efreq),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   // Scan results, taken from the registered search values.
   logic [FREQ_W-1:0] f_pick, above_pick, below_pick;

   assign f_pick     = (overload_ff || !ge_fnd_ff) ? tlast_ff : ge_ff;
   assign above_pick = gt_fnd_ff ? gt_ff : tlast_ff;
   assign below_pick = lt_fnd_ff ? lt_ff : t0_ff;

   logic [PROD_W-1:0] ratio_sat_lo;
   logic [PROD_W-1:0] ratio_cap_hi;

   assign ratio_sat_lo = (res > PROD_W'(PERMILLE_FULL)) ? PROD_W'(PERMILLE_FULL) : res;
   always_comb begin
      ratio_cap_hi = (res > PROD_W'(max_load_ff)) ? PROD_W'(max_load_ff) : res;
      if (ratio_cap_hi > PROD_W'(PERMILLE_FULL)) begin
         ratio_cap_hi = PROD_W'(PERMILLE_FULL);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (in_action)
                  ACT_SAMPLE: state_in = (in_total == '0) ? ST_OUT : ST_MUL_LOAD;
                  ACT_WMARKS: state_in = ST_SCAN_RD;
                  default:    state_in = ST_OUT;
               endcase
            end
         end
         ST_MUL_LOAD: if (unit_done) state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: begin
            if (unit_done) begin
               state_in = (res >= PROD_W'(max_load_ff)) ? ST_SCAN_RD : ST_MUL_REL;
            end
         end
         ST_MUL_REL:  if (unit_done) state_in = ST_DIV_REL;
         ST_DIV_REL:  if (unit_done) state_in = ST_DIV_CUR;
         ST_DIV_CUR:  if (unit_done) state_in = ST_MUL_KEY;
         ST_MUL_KEY:  if (unit_done) state_in = ST_SCAN_RD;
         ST_SCAN_RD:  state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (scan_idx_ff == last_idx) begin
               state_in = second_ff ? ST_SCAN2_END : ST_SCAN1_END;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN1_END: state_in = ST_DIV_KHZ;
         ST_DIV_KHZ:   if (unit_done) state_in = ST_SCAN_RD;
         ST_SCAN2_END: begin
            if (f_ff != t0_ff) begin
               state_in = ST_LO_DIV;
            end else if (f_ff != tlast_ff) begin
               state_in = ST_HI_DIV;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_LO_DIV:   if (unit_done) state_in = ST_LO_MUL;
         ST_LO_MUL:   if (unit_done) state_in = ST_LO_SCALE;
         ST_LO_SCALE: begin
            if (unit_done) begin
               state_in = (f_ff != tlast_ff) ? ST_HI_DIV : ST_OUT;
            end
         end
         ST_HI_DIV:   if (unit_done) state_in = ST_HI_MUL;
         ST_HI_MUL:   if (unit_done) state_in = ST_HI_SCALE;
         ST_HI_SCALE: if (unit_done) state_in = ST_OUT;
         ST_OUT:      if (rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Control outputs and operand selection.
   always_comb begin
      arith_state = 1'b1;
      cmd.op      = OP_DIV;
      opa         = res;
      opb         = THOUSAND;
      case (state_ff)
         ST_MUL_LOAD: begin
            cmd.op = OP_MUL;
            opa    = PROD_W'(busy_ff);
         end
         ST_DIV_LOAD: opb = total_ff;
         ST_MUL_REL:  cmd.op = OP_MUL;
         ST_DIV_REL:  opb = (tgt_load_ff == '0) ? 32'd1 : FREQ_W'(tgt_load_ff);
         ST_DIV_CUR:  opa = PROD_W'(cur_ff);
         ST_MUL_KEY: begin
            cmd.op = OP_MUL;
            opb    = FREQ_W'(rel_ff);
         end
         ST_DIV_KHZ:  opa = PROD_W'(f_ff);
         ST_LO_DIV: begin
            opa = PROD_W'(below_ff);
            opb = khz_ff;
         end
         ST_HI_DIV: begin
            opa = PROD_W'(above_ff);
            opb = khz_ff;
         end
         ST_LO_MUL, ST_HI_MUL: begin
            cmd.op = OP_MUL;
            opb    = FREQ_W'(tgt_load_ff);
         end
         ST_LO_SCALE, ST_HI_SCALE: ;
         default: arith_state = 1'b0;
      endcase
      cmd.start  = arith_state && !launch_ff;
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         launch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (unit_done) begin
            launch_ff <= 1'b0;
         end else if (cmd.start) begin
            launch_ff <= 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff != ST_SCAN_RD && state_ff != ST_SCAN_CHK) begin
         scan_idx_ff <= '0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_ff      <= in_action;
               busy_ff     <= in_busy;
               total_ff    <= in_total;
               cur_ff      <= in_cur;
               overload_ff <= 1'b0;
               second_ff   <= 1'b0;
               key_ff      <= '0;
               target_ff   <= '0;
               fv_ff       <= 1'b0;
               wv_ff       <= 1'b0;
               lo_ff       <= '0;
               hi_ff       <= '0;
               if (in_action == ACT_SAMPLE && in_total == '0) begin
                  target_ff <= in_cur;
                  fv_ff     <= 1'b1;
               end
            end
         end
         ST_DIV_LOAD: begin
            if (unit_done) begin
               overload_ff <= (res >= PROD_W'(max_load_ff));
            end
         end
         ST_DIV_REL: if (unit_done) rel_ff <= res[19:0];
         ST_MUL_KEY: if (unit_done) key_ff <= res;
         ST_SCAN_CHK: begin
            // The first entry checked starts a fresh search.
            if (scan_idx_ff == '0) begin
               t0_ff <= rd_data;
            end
            if (scan_idx_ff == last_idx) begin
               tlast_ff <= rd_data;
            end else begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
            if (scan_idx_ff == '0 || !ge_fnd_ff) begin
               ge_fnd_ff <= (PROD_W'(rd_data) >= key_ff);
               ge_ff     <= rd_data;
            end
            if (scan_idx_ff == '0 || !gt_fnd_ff) begin
               gt_fnd_ff <= (PROD_W'(rd_data) > key_ff);
               gt_ff     <= rd_data;
            end
            if (PROD_W'(rd_data) < key_ff) begin
               lt_fnd_ff <= 1'b1;
               lt_ff     <= rd_data;
            end else if (scan_idx_ff == '0) begin
               lt_fnd_ff <= 1'b0;
            end
         end
         ST_SCAN1_END: begin
            f_ff      <= f_pick;
            key_ff    <= PROD_W'(f_pick);
            second_ff <= 1'b1;
            wv_ff     <= 1'b1;
            if (act_ff == ACT_SAMPLE) begin
               target_ff <= f_pick;
               fv_ff     <= 1'b1;
            end
         end
         ST_DIV_KHZ: begin
            if (unit_done) begin
               khz_ff <= (res == '0) ? 32'd1 : res[FREQ_W-1:0];
            end
         end
         ST_SCAN2_END: begin
            above_ff <= above_pick;
            below_ff <= below_pick;
            lo_ff    <= '0;
            hi_ff    <= PERMILLE_FULL;
         end
         ST_LO_SCALE: if (unit_done) lo_ff <= ratio_sat_lo[PERMILLE_W-1:0];
         ST_HI_SCALE: if (unit_done) hi_ff <= ratio_cap_hi[PERMILLE_W-1:0];
         default: ;
      endcase
   end

   assign rsp_tdata = {4'b0, hi_ff, lo_ff, target_ff};
   assign rsp_tuser = {wv_ff, fv_ff};

endmodule
`default_nettype wire

// ----- design/lwdg_checker.sv -----
// Port-level checker for the load watermark frequency governor, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module lwdg_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [135:0] req_tdata,
   input wire logic [1:0]   req_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [55:0]  rsp_tdata,
   input wire logic [1:0]   rsp_tuser,
   input wire logic         csr_we,
   input wire logic [1:0]   csr_index,
   input wire logic [9:0]   csr_wdata
);

   logic unused_ok;
   assign unused_ok = ^{req_tvalid, req_tdata, req_tuser, csr_we, csr_index, csr_wdata};

   // A result stays offered until the receiver takes it.
   `LWDG_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")

   // One item at a time: no new transfer right after one was taken.
   `LWDG_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "input taken twice in a row")

   // Without a frequency decision the frequency field reads zero.
   `LWDG_ASSERT(a_freq_zero, !(rsp_tvalid && !rsp_tuser[0]) || rsp_tdata[31:0] == 32'd0, "target_freq set without freq_valid")

   // Watermarks are zero unless recomputed, and never exceed full scale.
   `LWDG_ASSERT(a_wm_zero, !(rsp_tvalid && !rsp_tuser[1]) || rsp_tdata[51:32] == 20'd0, "watermarks set without wmarks_valid")
   `LWDG_ASSERT(a_wm_range, !rsp_tvalid || (rsp_tdata[41:32] <= 10'd1000 && rsp_tdata[51:42] <= 10'd1000), "watermark above 1000")

endmodule

bind load_watermark_dvfs_governor_top lwdg_checker u_lwdg_checker (.*);
`default_nettype wire
